### sv/assert_macros.svh
// Assertion macros shared by the gap feed control RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication violated");

`endif

### sv/edmgf_pkg.sv
// Shared widths, constants and register indexes of the gap feed control block.
package edmgf_pkg;

  localparam int ADC_W    = 10;
  localparam int LEVEL_W  = 18;
  localparam int ALPHA_W  = 9;
  localparam int FRAC_W   = 8;
  localparam int OVR_W    = 8;
  localparam int POS_W    = 32;
  localparam int RATE_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_AXES = 3;

  localparam logic [ALPHA_W-1:0] Q_ONE       = 9'd256;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd26;
  localparam logic [LEVEL_W-1:0] AVG_RESET   = 18'd78080;
  localparam logic [LEVEL_W-1:0] SETPOINT_RESET = 18'd78080;
  localparam logic [LEVEL_W-1:0] SHORT_RESET = 18'd25600;

  localparam logic [OVR_W-1:0] OVR_MIN   = 8'd10;
  localparam logic [OVR_W-1:0] OVR_MAX   = 8'd200;
  localparam logic [OVR_W-1:0] OVR_RESET = 8'd100;
  localparam logic [OVR_W-1:0] OVR_UP    = 8'd1;
  localparam logic [OVR_W-1:0] OVR_DOWN  = 8'd5;

  typedef logic [RATE_W-1:0] rate_t;
  localparam rate_t RATE_ZERO = 2'd0;
  localparam rate_t RATE_SLOW = 2'd1;
  localparam rate_t RATE_FAST = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_EMA_ALPHA = 2'd0;
  localparam cfg_idx_t REG_SETPOINT  = 2'd1;
  localparam cfg_idx_t REG_SHORT     = 2'd2;

endpackage

### sv/edm_gap_feed_control_core.sv
// Top level of the EDM gap feed control: averaging, override, short recovery.
//
// Usage: one request on the input channel (in_valid/in_ready) is one sample
// tick with the gap conversion, mode flags and the axis position. Each request
// yields exactly one result on the output channel (out_valid/out_ready).
// in_ready is high only while the sequencer is idle; a request runs through
// four more steps (product, average, control, result); the result is
// registered in the result step, and no new request is taken until the last
// one has left that step. Both products of the average are formed in the
// product step; the history read is a single OR across the chain of cells.
// The result sits in an output register: while the receiver stalls, the next
// request is still taken and worked on, and it waits in its last step until
// the pending result has been taken.
// Configuration writes (cfg_valid/cfg_ready) are always taken; they are to be
// issued only while no request is in flight. Reset (rst, synchronous) restores
// the default registers, the average, override 100 and leaves recovery idle.
`include "assert_macros.svh"

module edm_gap_feed_control_core
  import edmgf_pkg::*;
#(
  parameter int HISTORY_DEPTH = 16,
  parameter int AXES          = 3
) (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration port.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [LEVEL_W-1:0]        cfg_data,
  // Sample input.
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ADC_W-1:0]          adc_sample,
  input  logic                      flood_enable,
  input  logic                      mist_enable,
  input  logic                      machine_idle,
  input  logic                      motion_busy,
  input  logic signed [POS_W-1:0]   pos_x,
  input  logic signed [POS_W-1:0]   pos_y,
  input  logic signed [POS_W-1:0]   pos_z,
  // Result output.
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [OVR_W-1:0]          feed_override,
  output logic                      override_changed,
  output logic                      hold_request,
  output logic                      move_valid,
  output logic signed [POS_W-1:0]   move_x,
  output logic signed [POS_W-1:0]   move_y,
  output logic signed [POS_W-1:0]   move_z,
  output logic [RATE_W-1:0]         move_rate,
  output logic                      resume_request,
  output logic                      recovering
);

  localparam int PTR_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int HIST_W = AXES * POS_W;
  localparam int PROD_W = ALPHA_W + LEVEL_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(HISTORY_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_AVG,
    S_CTRL,
    S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [ALPHA_W-1:0] ema_alpha;
  logic [LEVEL_W-1:0] setpoint_level;
  logic [LEVEL_W-1:0] short_level;

  // Architectural state.
  logic [LEVEL_W-1:0] avg_level;
  logic [OVR_W-1:0]   ovr;
  logic               rec;
  logic               rest;
  logic [PTR_W-1:0]   hist_count;
  logic [PTR_W-1:0]   hist_ptr;

  // Latched request.
  logic [ADC_W-1:0]   adc_q;
  logic               flood_q;
  logic               mist_q;
  logic               idle_q;
  logic               busy_q;
  logic [POS_W-1:0]   pos_q [MAX_AXES];

  // Products of the average.
  logic [PROD_W-1:0]  prod_new;
  logic [PROD_W-1:0]  prod_old;

  // Flags of the request being finished.
  logic               r_changed;
  logic               r_hold;
  logic               r_valid;
  rate_t              r_rate;
  logic               r_resume;

  logic [ALPHA_W-1:0] alpha_eff;
  logic [SUM_W-1:0]   avg_sum;
  logic [LEVEL_W-1:0] avg_next;

  logic               hit;
  logic               rec1;
  logic               step;
  logic               gt_short;
  logic               lt_short;
  logic               rest1;
  logic [PTR_W-1:0]   ptr_next;
  logic [PTR_W-1:0]   count_next;
  logic               valid_next;
  logic               done;
  logic               rec_next;
  logic               rest_next;
  rate_t              rate_next;
  logic [OVR_W:0]     ov_step;
  logic [OVR_W-1:0]   ov_clamped;
  logic [OVR_W-1:0]   ovr_next;
  logic               changed_next;

  logic               push;
  logic [HIST_W-1:0]  push_data;
  logic [HIST_W-1:0]  rd_data;
  logic [POS_W-1:0]   move_sel [MAX_AXES];
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign push      = (state == S_CTRL) && hit;

  // Average datapath.
  assign alpha_eff = (ema_alpha > Q_ONE) ? Q_ONE : ema_alpha;
  assign avg_sum   = SUM_W'(prod_new) + SUM_W'(prod_old) + SUM_W'(128);
  assign avg_next  = avg_sum[FRAC_W +: LEVEL_W];

  // Short detection and recovery step, on the registered average.
  always_comb begin
    gt_short = avg_level > short_level;
    lt_short = avg_level < short_level;
    hit      = mist_q && !rec && !idle_q && lt_short;
    rec1     = rec || hit;
    step     = mist_q && rec1 && !busy_q;
    rest1    = rest || (step && gt_short);

    count_next = hit ? ((hist_count < DEPTH_P) ? hist_count + PTR_W'(1) : DEPTH_P)
                     : hist_count;

    ptr_next  = hist_ptr;
    rate_next = RATE_ZERO;
    if (step && lt_short) begin
      ptr_next  = (hist_ptr < DEPTH_P) ? hist_ptr + PTR_W'(1) : DEPTH_P;
      rate_next = RATE_FAST;
    end else if (step && gt_short) begin
      ptr_next  = (hist_ptr != '0) ? hist_ptr - PTR_W'(1) : hist_ptr;
      rate_next = RATE_SLOW;
    end

    valid_next = step && (ptr_next < count_next);
    done       = valid_next && (ptr_next == '0) && rest1;
    rec_next   = rec1 && !done;
    rest_next  = rest1 && !done;
    if (!valid_next) begin
      rate_next = RATE_ZERO;
    end
  end

  // Feed override regulation.
  always_comb begin
    if (avg_level > setpoint_level) begin
      ov_step = {1'b0, ovr} + (OVR_W + 1)'(OVR_UP);
    end else if (avg_level < setpoint_level) begin
      ov_step = (ovr >= OVR_DOWN) ? {1'b0, ovr - OVR_DOWN} : '0;
    end else begin
      ov_step = {1'b0, ovr};
    end

    if (ov_step > {1'b0, OVR_MAX}) begin
      ov_clamped = OVR_MAX;
    end else if (ov_step < {1'b0, OVR_MIN}) begin
      ov_clamped = OVR_MIN;
    end else begin
      ov_clamped = ov_step[OVR_W-1:0];
    end

    if (flood_q && !rec_next) begin
      ovr_next     = ov_clamped;
      changed_next = ov_clamped != ovr;
    end else begin
      ovr_next     = ovr;
      changed_next = 1'b0;
    end
  end

  // Pack the recorded axes; axes beyond AXES are not stored.
  for (genvar a = 0; a < MAX_AXES; a++) begin : g_axis
    if (a < AXES) begin : g_used
      assign push_data[a*POS_W +: POS_W] = pos_q[a];
      assign move_sel[a] = r_valid ? rd_data[a*POS_W +: POS_W] : '0;
    end else begin : g_unused
      assign move_sel[a] = '0;
    end
  end

  edmgf_history #(
    .DEPTH (HISTORY_DEPTH),
    .AXES  (AXES)
  ) u_history (
    .clk       (clk),
    .push      (push),
    .push_data (push_data),
    .rd_ptr    (hist_ptr),
    .rd_data   (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      ema_alpha      <= ALPHA_RESET;
      setpoint_level <= SETPOINT_RESET;
      short_level    <= SHORT_RESET;
      avg_level      <= AVG_RESET;
      ovr            <= OVR_RESET;
      rec            <= 1'b0;
      rest           <= 1'b0;
      hist_count     <= '0;
      hist_ptr       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EMA_ALPHA: ema_alpha      <= cfg_data[ALPHA_W-1:0];
          REG_SETPOINT:  setpoint_level <= cfg_data;
          REG_SHORT:     short_level    <= cfg_data;
          default: ;
        endcase
      end

      // A new result may replace the one taken at this edge.
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            adc_q    <= adc_sample;
            flood_q  <= flood_enable;
            mist_q   <= mist_enable;
            idle_q   <= machine_idle;
            busy_q   <= motion_busy;
            pos_q[0] <= pos_x;
            pos_q[1] <= pos_y;
            pos_q[2] <= pos_z;
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          prod_new <= PROD_W'(alpha_eff) * PROD_W'({adc_q, {FRAC_W{1'b0}}});
          prod_old <= PROD_W'(Q_ONE - alpha_eff) * PROD_W'(avg_level);
          state    <= S_AVG;
        end
        S_AVG: begin
          avg_level <= avg_next;
          state     <= S_CTRL;
        end
        S_CTRL: begin
          rec        <= rec_next;
          rest       <= rest_next;
          hist_count <= count_next;
          hist_ptr   <= ptr_next;
          ovr        <= ovr_next;
          r_changed  <= changed_next;
          r_hold     <= hit;
          r_valid    <= valid_next;
          r_rate     <= rate_next;
          r_resume   <= done;
          state      <= S_OUT;
        end
        S_OUT: begin
          // The history now holds the pushed entry and the pointer is updated.
          if (out_free) begin
            feed_override    <= ovr;
            override_changed <= r_changed;
            hold_request     <= r_hold;
            move_valid       <= r_valid;
            move_x           <= move_sel[0];
            move_y           <= move_sel[1];
            move_z           <= move_sel[2];
            move_rate        <= r_rate;
            resume_request   <= r_resume;
            recovering       <= rec;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_resume_ends, clk, rst, out_valid && resume_request, move_valid && !recovering)
  `ASSERT_IMPLIES(a_hold_recovers, clk, rst, out_valid && hold_request, recovering)
  `ASSERT_IMPLIES(a_ovr_range, clk, rst, out_valid, feed_override >= OVR_MIN && feed_override <= OVR_MAX)
  `ASSERT_IMPLIES(a_stack_cap, clk, rst, 1'b1, hist_ptr <= DEPTH_P && hist_count <= DEPTH_P)
  `ASSERT_NEXT(a_ctrl_to_out, clk, rst, state == S_CTRL, state == S_OUT)

endmodule

### sv/edmgf_hist_cell.sv
// One entry of the position history chain: holds a position and passes it on.
module edmgf_hist_cell #(
  parameter int WIDTH = 96,
  parameter int PTR_W = 5,
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  logic             shift,
  input  logic [WIDTH-1:0] shift_in,
  input  logic [PTR_W-1:0] rd_ptr,
  output logic [WIDTH-1:0] data_out,
  output logic [WIDTH-1:0] rd_out
);

  logic [WIDTH-1:0] entry;

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= shift_in;
    end
  end

  assign data_out = entry;
  // Only the addressed cell drives its entry onto the read bus.
  assign rd_out   = (rd_ptr == PTR_W'(INDEX)) ? entry : '0;

endmodule

### sv/edmgf_history.sv
// Position history stack built as a shifting chain of cells with a read bus.
module edmgf_history
  import edmgf_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AXES  = 3,
  localparam int WIDTH = AXES * POS_W,
  localparam int PTR_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic [PTR_W-1:0] rd_ptr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] chain [DEPTH];
  logic [WIDTH-1:0] taps  [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    edmgf_hist_cell #(
      .WIDTH (WIDTH),
      .PTR_W (PTR_W),
      .INDEX (k)
    ) u_cell (
      .clk      (clk),
      .shift    (push),
      .shift_in ((k == 0) ? push_data : chain[(k == 0) ? 0 : k - 1]),
      .rd_ptr   (rd_ptr),
      .data_out (chain[k]),
      .rd_out   (taps[k])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_data = rd_data | taps[k];
    end
  end

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the EDM gap feed control core with a built-in predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import edmgf_pkg::*;

  localparam real CLK_PERIOD  = 8.0;
  localparam int  HIST_DEPTH  = 16;
  localparam int  ADC_MAX     = 1023;
  localparam int  LEVEL_MAX   = ADC_MAX << FRAC_W;
  localparam int  TICK_TARGET = 550;
  localparam int  CYCLE_LIMIT = 200000;
  localparam int  DRAIN_LIMIT = 2000;
  localparam int  SETTLE      = 8;
  localparam int  HOLD_CYCLES = 120;
  localparam int  MAX_REPORTS = 50;

  typedef struct packed {
    logic [ADC_W-1:0] adc;
    logic             flood, mist, idle, busy;
    logic [POS_W-1:0] x, y, z;
  } gap_tick_t;

  typedef struct packed {
    logic [OVR_W-1:0] ovr;
    logic             changed, hold, move_ok;
    logic [POS_W-1:0] mx, my, mz;
    rate_t            rate;
    logic             resume, recov;
  } feed_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_EMA_ALPHA;
  logic [LEVEL_W-1:0]     cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [ADC_W-1:0]       adc_sample = '0;
  logic                   flood_enable = 1'b0;
  logic                   mist_enable = 1'b0;
  logic                   machine_idle = 1'b0;
  logic                   motion_busy = 1'b0;
  logic signed [POS_W-1:0] pos_x = '0;
  logic signed [POS_W-1:0] pos_y = '0;
  logic signed [POS_W-1:0] pos_z = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [OVR_W-1:0]       feed_override;
  logic                   override_changed;
  logic                   hold_request;
  logic                   move_valid;
  logic signed [POS_W-1:0] move_x;
  logic signed [POS_W-1:0] move_y;
  logic signed [POS_W-1:0] move_z;
  logic [RATE_W-1:0]      move_rate;
  logic                   resume_request;
  logic                   recovering;

  edm_gap_feed_control_core DUT (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor copy of the registers and of the block state.
  logic [ALPHA_W-1:0] alpha_reg    = ALPHA_RESET;
  logic [LEVEL_W-1:0] setpoint_reg = SETPOINT_RESET;
  logic [LEVEL_W-1:0] short_reg    = SHORT_RESET;
  logic [LEVEL_W-1:0] avg_level    = AVG_RESET;
  logic [OVR_W-1:0]   ovr_level    = OVR_RESET;
  logic               in_recovery  = 1'b0;
  logic               restoring_fwd = 1'b0;
  int                 hist_count   = 0;
  int                 hist_ptr     = 0;
  logic [POS_W-1:0]   hist_pos [HIST_DEPTH][MAX_AXES];

  feed_result_t feed_results_q[$];
  feed_result_t want, seen;

  bit no_gaps   = 1'b0;
  bit sink_hold = 1'b0;
  int sink_wait = 0;
  int error_count = 0;
  int ticks_sent = 0;
  int settings_written = 0;
  int holds_seen = 0, moves_seen = 0, resumes_seen = 0;
  int ovr_lo = 255, ovr_hi = 0;
  int cycle_count;
  event hold_start;

  function automatic feed_result_t predict_feed_result(gap_tick_t t);
    feed_result_t r;
    int unsigned weight, acc, ov;
    int k, ax;
    r = '0;
    weight = (alpha_reg > Q_ONE) ? Q_ONE : alpha_reg;
    acc = weight * (int'(t.adc) << FRAC_W) + (Q_ONE - weight) * avg_level
          + (1 << (FRAC_W - 1));
    avg_level = acc >> FRAC_W;

    if (t.mist) begin
      if (!in_recovery && !t.idle && avg_level < short_reg) begin
        r.hold = 1'b1;
        if (hist_count < HIST_DEPTH) hist_count++;
        // The newest position sits on top; the oldest one falls off at the cap.
        for (k = hist_count - 1; k > 0; k--)
          for (ax = 0; ax < MAX_AXES; ax++) hist_pos[k][ax] = hist_pos[k-1][ax];
        hist_pos[0][0] = t.x;
        hist_pos[0][1] = t.y;
        hist_pos[0][2] = t.z;
        in_recovery = 1'b1;
      end
      if (in_recovery && !t.busy) begin
        if (avg_level > short_reg && !restoring_fwd) restoring_fwd = 1'b1;
        if (avg_level < short_reg) begin
          if (hist_ptr < HIST_DEPTH) hist_ptr++;
          r.rate = RATE_FAST;
        end
        if (avg_level > short_reg && restoring_fwd) begin
          if (hist_ptr != 0) hist_ptr--;
          r.rate = RATE_SLOW;
        end
        if (hist_ptr < hist_count) begin
          r.move_ok = 1'b1;
          r.mx = hist_pos[hist_ptr][0];
          r.my = hist_pos[hist_ptr][1];
          r.mz = hist_pos[hist_ptr][2];
          if (hist_ptr == 0 && restoring_fwd) begin
            in_recovery = 1'b0;
            restoring_fwd = 1'b0;
            r.resume = 1'b1;
          end
        end
      end
    end

    if (t.flood && !in_recovery) begin
      ov = ovr_level;
      if (avg_level > setpoint_reg) ov = ov + OVR_UP;
      if (avg_level < setpoint_reg) ov = (ov >= OVR_DOWN) ? ov - OVR_DOWN : 0;
      if (ov > OVR_MAX) ov = OVR_MAX;
      if (ov < OVR_MIN) ov = OVR_MIN;
      r.changed = (ov != ovr_level);
      ovr_level = ov;
    end

    if (!r.move_ok) r.rate = RATE_ZERO;
    r.ovr = ovr_level;
    r.recov = in_recovery;
    return r;
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic gap_tick_t tick_at(logic [ADC_W-1:0] adc, logic flood, logic mist,
                                        logic idle, logic busy, logic [POS_W-1:0] x,
                                        logic [POS_W-1:0] y, logic [POS_W-1:0] z);
    gap_tick_t t;
    t.adc = adc;
    t.flood = flood;
    t.mist = mist;
    t.idle = idle;
    t.busy = busy;
    t.x = x;
    t.y = y;
    t.z = z;
    return t;
  endfunction

  function automatic gap_tick_t tick_of(logic [ADC_W-1:0] adc, logic flood, logic mist,
                                        logic idle, logic busy);
    return tick_at(adc, flood, mist, idle, busy, rand_pos(), rand_pos(), rand_pos());
  endfunction

  function automatic gap_tick_t random_tick();
    return tick_of($urandom_range(0, ADC_MAX), $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 1), $urandom_range(0, 1));
  endfunction

  // Offers one tick and records its prediction once the request is taken.
  task automatic send_tick(gap_tick_t t);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    adc_sample   <= t.adc;
    flood_enable <= t.flood;
    mist_enable  <= t.mist;
    machine_idle <= t.idle;
    motion_busy  <= t.busy;
    pos_x        <= t.x;
    pos_y        <= t.y;
    pos_z        <= t.z;
    do @(posedge clk); while (!in_ready);
    feed_results_q.push_back(predict_feed_result(t));
    ticks_sent++;
  endtask

  task automatic drain_results();
    int n;
    in_valid <= 1'b0;
    for (n = 0; n < DRAIN_LIMIT && feed_results_q.size() != 0; n++) @(posedge clk);
    if (feed_results_q.size() != 0) begin
      error_count++;
      $display("%0t: %0d results never arrived", $time, feed_results_q.size());
      feed_results_q.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [LEVEL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_EMA_ALPHA: alpha_reg = value[ALPHA_W-1:0];
      REG_SETPOINT:  setpoint_reg = value;
      REG_SHORT:     short_reg = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [ALPHA_W-1:0] alpha, logic [LEVEL_W-1:0] setpoint,
                                logic [LEVEL_W-1:0] short_lvl);
    drain_results();
    write_reg(REG_EMA_ALPHA, alpha);
    write_reg(REG_SETPOINT, setpoint);
    write_reg(REG_SHORT, short_lvl);
    cfg_valid <= 1'b0;
    settings_written++;
  endtask

  // A short followed by a clearing gap. With a weight of one or more the average
  // equals the sample, so the sample alone decides shorted, equal or clear.
  task automatic run_short_episode(int shorted_len);
    int thr, n, pick;
    logic [ADC_W-1:0] adc;
    thr = short_reg >> FRAC_W;
    if (thr < 1 || thr > ADC_MAX - 1) return;
    no_gaps = ($urandom_range(0, 4) == 0);
    send_tick(tick_of($urandom_range(0, thr - 1), $urandom_range(0, 1), 1'b1, 1'b0,
                      $urandom_range(0, 3) == 0));
    for (n = 1; n < shorted_len; n++)
      send_tick(tick_of($urandom_range(0, thr - 1), $urandom_range(0, 1), 1'b1,
                        $urandom_range(0, 1), $urandom_range(0, 3) == 0));
    for (n = 0; n < 48 && in_recovery; n++) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) adc = $urandom_range(0, thr - 1);
      else if (pick == 1) adc = thr;
      else adc = $urandom_range(thr + 1, ADC_MAX);
      send_tick(tick_of(adc, $urandom_range(0, 1), pick != 2, $urandom_range(0, 1),
                        $urandom_range(0, 3) == 0));
    end
  endtask

  task automatic test_reset_settings();
    send_tick(tick_at(0, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0));
    send_tick(tick_at(ADC_MAX, 1'b1, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'h1));
    send_tick(tick_at(ADC_MAX, 1'b0, 1'b0, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h5555_AAAA));
    send_tick(tick_at(512, 1'b1, 1'b1, 1'b0, 1'b0, rand_pos(), rand_pos(), rand_pos()));
  endtask

  task automatic test_directed_recovery();
    apply_settings(Q_ONE, 512 << FRAC_W, 200 << FRAC_W);
    send_tick(tick_at(ADC_MAX, 1'b1, 1'b0, 1'b0, 1'b0, 32'h1, 32'h2, 32'h3));
    send_tick(tick_at(0, 1'b1, 1'b0, 1'b0, 1'b0, 32'h1, 32'h2, 32'h3));
    send_tick(tick_at(512, 1'b1, 1'b0, 1'b0, 1'b0, 32'h1, 32'h2, 32'h3));
    // An idle machine never starts a recovery.
    send_tick(tick_at(0, 1'b1, 1'b1, 1'b1, 1'b0, 32'h1, 32'h2, 32'h3));
    // Short while a move is still running: hold only, no step.
    send_tick(tick_at(0, 1'b1, 1'b1, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    // Still shorted: pointer runs past the single entry, no move.
    send_tick(tick_at(0, 1'b1, 1'b1, 1'b0, 1'b0, 32'h10, 32'h20, 32'h30));
    send_tick(tick_at(200, 1'b1, 1'b1, 1'b0, 1'b0, 32'h10, 32'h20, 32'h30));
    send_tick(tick_at(ADC_MAX, 1'b1, 1'b0, 1'b0, 1'b0, 32'h10, 32'h20, 32'h30));
    send_tick(tick_at(ADC_MAX, 1'b1, 1'b1, 1'b0, 1'b1, 32'h10, 32'h20, 32'h30));
    send_tick(tick_at(ADC_MAX, 1'b1, 1'b1, 1'b0, 1'b0, 32'h10, 32'h20, 32'h30));
    // Second short: two entries deep, back out fast, then forward slowly to resume.
    send_tick(tick_at(0, 1'b0, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000));
    send_tick(tick_at(0, 1'b1, 1'b1, 1'b0, 1'b0, 32'h44, 32'h55, 32'h66));
    send_tick(tick_at(ADC_MAX, 1'b1, 1'b1, 1'b0, 1'b0, 32'h44, 32'h55, 32'h66));
    send_tick(tick_at(ADC_MAX, 1'b1, 1'b1, 1'b0, 1'b0, 32'h44, 32'h55, 32'h66));
    send_tick(tick_at(ADC_MAX, 1'b1, 1'b0, 1'b0, 1'b0, 32'h44, 32'h55, 32'h66));
    // A weight above one behaves as one.
    apply_settings(9'h1FF, 512 << FRAC_W, 200 << FRAC_W);
    send_tick(tick_at(0, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0));
    send_tick(tick_at(ADC_MAX, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0));
  endtask

  task automatic test_recovery_sequences(int tick_limit);
    int len;
    apply_settings(Q_ONE, $urandom_range(0, ADC_MAX) << FRAC_W,
                   $urandom_range(50, 900) << FRAC_W);
    while (ticks_sent < tick_limit) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 20) : $urandom_range(1, 5);
      run_short_episode(len);
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 4)) send_tick(random_tick());
    end
  endtask

  task automatic test_override_limits();
    int n;
    apply_settings(9'h1FF, 0, 300 << FRAC_W);
    run_short_episode(1);
    no_gaps = 1'b0;
    // Any nonzero average is above a zero setpoint, so the override climbs to its top.
    for (n = 0; n < 140; n++)
      send_tick(tick_of($urandom_range(1, ADC_MAX), $urandom_range(0, 9) != 0, 1'b0,
                        $urandom_range(0, 1), $urandom_range(0, 1)));
    // A frozen average under the highest setpoint drives it down to its floor.
    apply_settings(0, LEVEL_MAX, 0);
    no_gaps = 1'b1;
    for (n = 0; n < 40; n++)
      send_tick(tick_of($urandom_range(0, ADC_MAX), $urandom_range(0, 3) != 0,
                        $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1)));
    no_gaps = 1'b0;
  endtask

  task automatic test_short_level_extremes();
    int n;
    apply_settings(Q_ONE, $urandom_range(0, LEVEL_MAX), LEVEL_MAX);
    for (n = 0; n < 30; n++)
      send_tick(tick_of(($urandom_range(0, 3) == 0) ? ADC_MAX : $urandom_range(0, ADC_MAX),
                        $urandom_range(0, 1), $urandom_range(0, 7) != 0,
                        $urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0));
  endtask

  task automatic test_filtered_noise();
    int n;
    apply_settings($urandom_range(64, 255), $urandom_range(0, LEVEL_MAX),
                   $urandom_range(100 << FRAC_W, 600 << FRAC_W));
    for (n = 0; n < 4; n++) begin
      run_short_episode($urandom_range(2, 10));
      repeat (8) send_tick(random_tick());
    end
  endtask

  task automatic test_output_backpressure();
    -> hold_start;
    no_gaps = 1'b1;
    repeat (16) send_tick(random_tick());
    no_gaps = 1'b0;
  endtask

  // Long receiver stall so that the block fills and pushes back on its input.
  initial begin
    forever begin
      @(hold_start);
      sink_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      sink_hold <= 1'b0;
    end
  end

  task automatic check_field(string name, logic [POS_W-1:0] want_v, logic [POS_W-1:0] got_v);
    if (got_v !== want_v) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      seen.ovr = feed_override;
      seen.changed = override_changed;
      seen.hold = hold_request;
      seen.move_ok = move_valid;
      seen.mx = move_x;
      seen.my = move_y;
      seen.mz = move_z;
      seen.rate = move_rate;
      seen.resume = resume_request;
      seen.recov = recovering;
      if (feed_results_q.size() == 0) begin
        error_count++;
        $display("%0t: result with no request outstanding, override %0d", $time,
                 feed_override);
      end else begin
        want = feed_results_q.pop_front();
        check_field("feed_override", want.ovr, seen.ovr);
        check_field("override_changed", want.changed, seen.changed);
        check_field("hold_request", want.hold, seen.hold);
        check_field("move_valid", want.move_ok, seen.move_ok);
        check_field("move_x", want.mx, seen.mx);
        check_field("move_y", want.my, seen.my);
        check_field("move_z", want.mz, seen.mz);
        check_field("move_rate", want.rate, seen.rate);
        check_field("resume_request", want.resume, seen.resume);
        check_field("recovering", want.recov, seen.recov);
        holds_seen += want.hold;
        moves_seen += want.move_ok;
        resumes_seen += want.resume;
        if (want.ovr < ovr_lo) ovr_lo = want.ovr;
        if (want.ovr > ovr_hi) ovr_hi = want.ovr;
      end
      sink_wait = no_gaps ? 0 : $urandom_range(0, 10);
    end else if (!out_ready && sink_wait > 0) begin
      sink_wait--;
    end
    out_ready <= !rst && !sink_hold && sink_wait == 0;
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("%0t: run did not finish in %0d cycles", $time, CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_settings();
    test_directed_recovery();
    test_recovery_sequences(200);
    test_override_limits();
    test_short_level_extremes();
    test_filtered_noise();
    test_output_backpressure();
    test_recovery_sequences(TICK_TARGET);
    drain_results();
    $display("Covered %0d sample ticks under %0d register settings after reset.",
             ticks_sent, settings_written);
    $display("Saw %0d holds, %0d recovery moves, %0d resumes; override spanned %0d to %0d.",
             holds_seen, moves_seen, resumes_seen, ovr_lo, ovr_hi);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### edm_gap_feed_control_core.f
+incdir+sv
sv/edmgf_pkg.sv
sv/edmgf_hist_cell.sv
sv/edmgf_history.sv
sv/edm_gap_feed_control_core.sv
tb/sv/tb_top.sv
